// File: rtl/spmp_pkg.sv
// ============================================================================
// spmp_pkg
// Shared types and constants for the LIFO stack with multi-entry pop.
// ============================================================================
package spmp_pkg;

  localparam int VALUE_W = 25;
  localparam int COUNT_W = 7;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POP = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    take;       // latch the accepted word
    logic    push_wr;    // write item to top, bump level
    logic    emit_stat;  // load a single status result
    status_t stat;       // status code for emit_stat
    logic    start_pop;  // set read pointer and drop level
    logic    emit_pop;   // load one popped entry into the output
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;  // output register can take a result this cycle
    logic is_pop;     // held item is a pop
    logic full;       // level at capacity
    logic pop_bad;    // pop count zero or not below level
    logic pop_last;   // one entry left in the run
  } sts_t;

endpackage

// File: rtl/spmp_if.sv
// ============================================================================
// spmp_if
// Request and result channels: valid/ready handshake with payload.
// ============================================================================
interface spmp_req_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic signed [spmp_pkg::VALUE_W-1:0] push_value;
  logic        [spmp_pkg::COUNT_W-1:0] pop_count;

  modport source (output valid, output opcode, output push_value, output pop_count,
                  input ready);
  modport sink   (input valid, input opcode, input push_value, input pop_count,
                  output ready);
endinterface

interface spmp_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [spmp_pkg::VALUE_W-1:0] popped_value;
  logic        [1:0]                   status;
  logic                                last;

  modport source (output valid, output popped_value, output status, output last,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input last,
                  output ready);
endinterface

// File: rtl/spmp_ram.sv
// ============================================================================
// spmp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module spmp_ram #(
  parameter int WIDTH  = 25,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/spmp_ctrl.sv
// ============================================================================
// spmp_ctrl
// Sequencer: accepts a word, resolves push or pop, walks the pop run.
// ============================================================================
module spmp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  spmp_pkg::sts_t  sts,
  output spmp_pkg::cmd_t  cmd
);
  import spmp_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    POP
  } state_t;

  state_t state, state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.stat   = ST_OK;
    case (state)
      IDLE: begin
        in_ready = sts.slot_free;
        if (in_valid && sts.slot_free) begin
          cmd.take   = 1'b1;
          state_next = EXEC;
        end
      end
      EXEC: begin
        // output register is empty here: it was free when the word came in
        if (!sts.is_pop) begin
          cmd.emit_stat = 1'b1;
          if (sts.full) begin
            cmd.stat = ST_FULL;
          end else begin
            cmd.push_wr = 1'b1;
            cmd.stat    = ST_OK;
          end
          state_next = IDLE;
        end else if (sts.pop_bad) begin
          cmd.emit_stat = 1'b1;
          cmd.stat      = ST_BAD_POP;
          state_next    = IDLE;
        end else begin
          cmd.start_pop = 1'b1;
          state_next    = POP;
        end
      end
      POP: begin
        if (sts.slot_free) begin
          cmd.emit_pop = 1'b1;
          if (sts.pop_last) begin
            state_next = IDLE;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/spmp_dp.sv
// ============================================================================
// spmp_dp
// Datapath: held word, level, entry RAM, read pointer and result register.
// ============================================================================
module spmp_dp #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_opcode,
  input  logic signed [spmp_pkg::VALUE_W-1:0] in_push_value,
  input  logic        [spmp_pkg::COUNT_W-1:0] in_pop_count,
  input  spmp_pkg::cmd_t                      cmd,
  output spmp_pkg::sts_t                      sts,
  spmp_rsp_if.source                          rsp
);
  import spmp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;

  // held word
  logic               item_op;
  logic [VALUE_W-1:0] item_value;
  logic [COUNT_W-1:0] item_count;

  logic [LW-1:0]      level;
  logic [AW-1:0]      rd_idx, rd_idx_next;
  logic [COUNT_W-1:0] remaining;
  logic [VALUE_W-1:0] rd_data;
  logic [CW-1:0]      base;

  logic               out_valid;
  logic [VALUE_W-1:0] out_value;
  status_t            out_status;
  logic               out_last;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_op    <= in_opcode;
      item_value <= in_push_value;
      item_count <= in_pop_count;
    end
  end

  // status toward the controller
  assign base          = CW'(level) - CW'(item_count);
  assign sts.slot_free = !out_valid || rsp.ready;
  assign sts.is_pop    = (item_op == OP_POP);
  assign sts.full      = (level == LW'(DEPTH));
  assign sts.pop_bad   = (item_count == '0) || (CW'(item_count) >= CW'(level));
  assign sts.pop_last  = (remaining == COUNT_W'(1));

  // level
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (cmd.push_wr) begin
      level <= level + LW'(1);
    end else if (cmd.start_pop) begin
      level <= base[LW-1:0];
    end
  end

  // the next read pointer drives the RAM address, so rd_data tracks rd_idx
  always_comb begin
    rd_idx_next = rd_idx;
    if (cmd.start_pop) begin
      rd_idx_next = base[AW-1:0];
    end else if (cmd.emit_pop) begin
      rd_idx_next = rd_idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_idx_next;
    if (cmd.start_pop) begin
      remaining <= item_count;
    end else if (cmd.emit_pop) begin
      remaining <= remaining - COUNT_W'(1);
    end
  end

  spmp_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.push_wr),
    .wr_addr (level[AW-1:0]),
    .wr_data (item_value),
    .rd_addr (rd_idx_next),
    .rd_data (rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_stat || cmd.emit_pop) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_stat) begin
      out_value  <= '0;
      out_status <= cmd.stat;
      out_last   <= 1'b1;
    end else if (cmd.emit_pop) begin
      out_value  <= rd_data;
      out_status <= ST_OK;
      out_last   <= (remaining == COUNT_W'(1));
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.popped_value = out_value;
  assign rsp.status       = out_status;
  assign rsp.last         = out_last;

endmodule

// File: rtl/stack_push_multi_pop_unit.sv
// ============================================================================
// stack_push_multi_pop_unit
// LIFO stack of signed 25-bit values; a pop removes N top entries as a run.
// ============================================================================
//
//   Channel  Dir  Word fields                           Notes
//   req      in   opcode, push_value, pop_count         one word per command
//   rsp      out  popped_value, status, last            last marks end of run
//
// Push and refused pop: accept, then execute into the result register.
// Successful pop of N: accept, start the run, then one entry per cycle
// while the output is free, from the RAM's registered port. Reset clears
// state, level and out_valid only; the entry RAM needs no clearing pass.
// A stalled rsp holds the run; req is taken again once the output is free.
// ============================================================================
module stack_push_multi_pop_unit #(
  parameter int DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  spmp_req_if.sink   req,
  spmp_rsp_if.source rsp
);
  import spmp_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign req.ready = in_ready;

  spmp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spmp_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_opcode     (req.opcode),
    .in_push_value (req.push_value),
    .in_pop_count  (req.pop_count),
    .cmd           (cmd),
    .sts           (sts),
    .rsp           (rsp)
  );

endmodule
